// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the servo slew controller.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold at every rising edge of clk, off during reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ----- hdl/fjssc_pkg.sv -----
// Package for the four-joint servo slew controller: types, limits, codes,
// register reset values and the per-joint angle limit check. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fjssc_pkg;

	localparam int NUM_JOINTS = 4;

	localparam int BASE_MAX      = 180;
	localparam int SHOULDER_MAX  = 77;
	localparam int GRIP_MAX      = 37;
	localparam int ELBOW_MIN_SUM = 140;
	localparam int ELBOW_MAX_SUM = 196;
	localparam int ELBOW_MAX     = 180;
	localparam int MIN_SWING     = 5;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_SET_ONE = 2'd1,
		OP_SET_ALL = 2'd2,
		OP_HOME    = 2'd3
	} opcode_t;

	localparam logic [1:0] J_BASE     = 2'd0;
	localparam logic [1:0] J_SHOULDER = 2'd1;
	localparam logic [1:0] J_ELBOW    = 2'd2;
	localparam logic [1:0] J_GRIP     = 2'd3;

	localparam logic [2:0] REG_COMP_ENABLE     = 3'd0;
	localparam logic [2:0] REG_HEAVY_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_OVERSHOOT_ANGLE = 3'd2;
	localparam logic [2:0] REG_COMP_DELAY      = 3'd3;
	localparam logic [2:0] REG_SLOW_THRESHOLD  = 3'd4;
	localparam logic [2:0] REG_NORMAL_INTERVAL = 3'd5;
	localparam logic [2:0] REG_SLOW_INTERVAL   = 3'd6;
	localparam logic [2:0] REG_HOME_ANGLES     = 3'd7;

	localparam logic        RST_COMP_ENABLE     = 1'b1;
	localparam logic [6:0]  RST_HEAVY_THRESHOLD = 7'd30;
	localparam logic [6:0]  RST_OVERSHOOT_ANGLE = 7'd3;
	localparam logic [15:0] RST_COMP_DELAY      = 16'd150;
	localparam logic [7:0]  RST_SLOW_THRESHOLD  = 8'd40;
	localparam logic [7:0]  RST_NORMAL_INTERVAL = 8'd15;
	localparam logic [7:0]  RST_SLOW_INTERVAL   = 8'd25;
	localparam logic [31:0] RST_HOME_ANGLES     = 32'h0096_005A;

	typedef struct packed {
		opcode_t           opcode;
		logic [1:0]        joint;
		logic signed [8:0] angle;
		logic signed [8:0] base_angle;
		logic signed [8:0] shoulder_angle;
		logic signed [8:0] elbow_angle;
		logic signed [8:0] grip_angle;
	} item_t;

	typedef struct packed {
		logic                                 accepted;
		logic [NUM_JOINTS-1:0][7:0]           pos;
		logic [NUM_JOINTS-1:0]                write_mask;
		logic                                 compensating;
		logic                                 slow_mode;
	} result_t;

	// Limit check of one requested angle; sh is the shoulder angle that
	// sets the elbow window.
	function automatic logic angle_ok(input logic [1:0] j, input logic signed [8:0] a,
			input logic [7:0] sh);
		logic signed [10:0] aw;
		logic signed [10:0] lo;
		logic signed [10:0] hi;
		logic               ok;
		aw = 11'(a);
		lo = 11'(ELBOW_MIN_SUM) - $signed({3'b000, sh});
		hi = 11'(ELBOW_MAX_SUM) - $signed({3'b000, sh});
		if (hi > 11'(ELBOW_MAX))
			hi = 11'(ELBOW_MAX);
		case (j)
			J_BASE:     ok = (aw >= 0) && (aw <= 11'(BASE_MAX));
			J_SHOULDER: ok = (aw >= 0) && (aw <= 11'(SHOULDER_MAX));
			J_ELBOW:    ok = (aw >= lo) && (aw <= hi);
			default:    ok = (aw >= 0) && (aw <= 11'(GRIP_MAX));
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/four_joint_servo_slew_controller.sv -----
// Four-joint servo slew controller: one item register, one combinational
// update of the joint state, one result register. Uses fjssc_pkg and
// assert_macros.svh.
//
// Each item passes from the item register through the state update into the
// result register; a new item is taken every cycle unless out_stall holds a
// full result register. The state update is a single path that closes on the
// joint state registers. Tick items advance the step phase; every interval-th
// tick moves each joint one degree toward its target. Set commands are
// limit-checked, go home retargets to the home register. Configuration writes
// are always ready and take effect on the next item, interval writes on the next accepted set.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module four_joint_servo_slew_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           opcode,
	input  wire logic [1:0]           joint,
	input  wire logic signed [8:0]    angle,
	input  wire logic signed [8:0]    base_angle,
	input  wire logic signed [8:0]    shoulder_angle,
	input  wire logic signed [8:0]    elbow_angle,
	input  wire logic signed [8:0]    grip_angle,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      accepted,
	output logic [7:0]                base_pos,
	output logic [7:0]                shoulder_pos,
	output logic [7:0]                elbow_pos,
	output logic [7:0]                grip_pos,
	output logic [3:0]                write_mask,
	output logic                      compensating,
	output logic                      slow_mode,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);
	import fjssc_pkg::*;

	// configuration
	logic        comp_en_q;
	logic [6:0]  heavy_q;
	logic [6:0]  over_q;
	logic [15:0] delay_q;
	logic [7:0]  slow_thr_q;
	logic [7:0]  norm_int_q;
	logic [7:0]  slow_int_q;
	logic [31:0] home_q;

	// joint state
	logic [7:0]  cur_q [NUM_JOINTS];
	logic [7:0]  tgt_q [NUM_JOINTS];
	logic        comp_q;
	logic [15:0] elapsed_q;
	logic [7:0]  final_q;
	logic        slow_q;
	logic [7:0]  phase_q;
	logic [7:0]  intv_q;

	logic [7:0]  cur_n [NUM_JOINTS];
	logic [7:0]  tgt_n [NUM_JOINTS];
	logic        comp_n;
	logic [15:0] elapsed_n;
	logic [7:0]  final_n;
	logic        slow_n;
	logic [7:0]  phase_n;
	logic [7:0]  intv_n;

	item_t       item_s1;
	logic        valid_s1;
	result_t     res_q;
	logic        res_valid_q;
	result_t     res_n;
	logic        advance;

	logic [8:0]  phase_inc;
	logic        set_sh;
	logic [7:0]  sh_a;
	logic        reload;
	logic [3:0]  mask;
	logic        acc;
	logic [8:0]  swing;

	assign advance   = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{opcode: opcode_t'(opcode), joint: joint, angle: angle,
				base_angle: base_angle, shoulder_angle: shoulder_angle,
				elbow_angle: elbow_angle, grip_angle: grip_angle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_en_q  <= RST_COMP_ENABLE;
			heavy_q    <= RST_HEAVY_THRESHOLD;
			over_q     <= RST_OVERSHOOT_ANGLE;
			delay_q    <= RST_COMP_DELAY;
			slow_thr_q <= RST_SLOW_THRESHOLD;
			norm_int_q <= RST_NORMAL_INTERVAL;
			slow_int_q <= RST_SLOW_INTERVAL;
			home_q     <= RST_HOME_ANGLES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COMP_ENABLE:     comp_en_q  <= cfg_data[0];
				REG_HEAVY_THRESHOLD: heavy_q    <= cfg_data[6:0];
				REG_OVERSHOOT_ANGLE: over_q     <= cfg_data[6:0];
				REG_COMP_DELAY:      delay_q    <= cfg_data[15:0];
				REG_SLOW_THRESHOLD:  slow_thr_q <= cfg_data[7:0];
				REG_NORMAL_INTERVAL: norm_int_q <= cfg_data[7:0];
				REG_SLOW_INTERVAL:   slow_int_q <= cfg_data[7:0];
				REG_HOME_ANGLES:     home_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cur_n     = cur_q;
		tgt_n     = tgt_q;
		comp_n    = comp_q;
		elapsed_n = elapsed_q;
		final_n   = final_q;
		slow_n    = slow_q;
		phase_n   = phase_q;
		intv_n    = intv_q;
		phase_inc = {1'b0, phase_q} + 9'd1;
		set_sh    = 1'b0;
		sh_a      = '0;
		reload    = 1'b0;
		mask      = '0;
		acc       = 1'b0;
		swing     = '0;

		case (item_s1.opcode)
			OP_TICK: begin
				if (comp_q && (elapsed_q != 16'hFFFF))
					elapsed_n = elapsed_q + 16'd1;
				if (phase_inc >= {1'b0, intv_q}) begin
					phase_n = '0;
					if (comp_q && (elapsed_n >= delay_q)) begin
						tgt_n[J_SHOULDER] = final_q;
						comp_n = 1'b0;
					end
					slow_n = (cur_q[J_SHOULDER] >= slow_thr_q) ||
						(tgt_n[J_SHOULDER] >= slow_thr_q);
					for (int j = 0; j < NUM_JOINTS; j++) begin
						if (tgt_n[j] > cur_q[j]) begin
							cur_n[j] = cur_q[j] + 8'd1;
							mask[j]  = 1'b1;
						end else if (tgt_n[j] < cur_q[j]) begin
							cur_n[j] = cur_q[j] - 8'd1;
							mask[j]  = 1'b1;
						end
					end
				end else begin
					phase_n = phase_inc[7:0];
				end
			end
			OP_SET_ONE: begin
				if (angle_ok(item_s1.joint, item_s1.angle, cur_q[J_SHOULDER])) begin
					acc    = 1'b1;
					reload = 1'b1;
					if (item_s1.joint == J_SHOULDER) begin
						set_sh = 1'b1;
						sh_a   = item_s1.angle[7:0];
					end else begin
						tgt_n[item_s1.joint] = item_s1.angle[7:0];
					end
				end
			end
			OP_SET_ALL: begin
				if (angle_ok(J_BASE, item_s1.base_angle, 8'd0) &&
						angle_ok(J_SHOULDER, item_s1.shoulder_angle, 8'd0) &&
						angle_ok(J_ELBOW, item_s1.elbow_angle,
							item_s1.shoulder_angle[7:0]) &&
						angle_ok(J_GRIP, item_s1.grip_angle, 8'd0)) begin
					acc             = 1'b1;
					reload          = 1'b1;
					set_sh          = 1'b1;
					sh_a            = item_s1.shoulder_angle[7:0];
					tgt_n[J_BASE]   = item_s1.base_angle[7:0];
					tgt_n[J_ELBOW]  = item_s1.elbow_angle[7:0];
					tgt_n[J_GRIP]   = item_s1.grip_angle[7:0];
				end
			end
			OP_HOME: begin
				for (int j = 0; j < NUM_JOINTS; j++)
					tgt_n[j] = home_q[8*j +: 8];
			end
			default: ;
		endcase

		// overshoot on a large downward-in-angle shoulder move
		if (set_sh) begin
			swing = {1'b0, cur_q[J_SHOULDER]} - {1'b0, sh_a};
			if (comp_en_q && (sh_a < cur_q[J_SHOULDER]) && (sh_a >= {1'b0, heavy_q}) &&
					(swing >= 9'(MIN_SWING))) begin
				final_n           = sh_a;
				tgt_n[J_SHOULDER] = (sh_a >= {1'b0, over_q}) ? sh_a - {1'b0, over_q} : 8'd0;
				elapsed_n         = '0;
				comp_n            = 1'b1;
			end else begin
				tgt_n[J_SHOULDER] = sh_a;
			end
		end

		if (reload) begin
			intv_n  = slow_q ? slow_int_q : norm_int_q;
			phase_n = '0;
		end

		res_n.accepted     = acc;
		res_n.write_mask   = mask;
		res_n.compensating = comp_n;
		res_n.slow_mode    = slow_n;
		for (int j = 0; j < NUM_JOINTS; j++)
			res_n.pos[j] = cur_n[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				cur_q[j] <= RST_HOME_ANGLES[8*j +: 8];
				tgt_q[j] <= RST_HOME_ANGLES[8*j +: 8];
			end
			comp_q    <= 1'b0;
			elapsed_q <= '0;
			final_q   <= '0;
			slow_q    <= 1'b0;
			phase_q   <= '0;
			intv_q    <= RST_NORMAL_INTERVAL;
		end else if (advance) begin
			cur_q     <= cur_n;
			tgt_q     <= tgt_n;
			comp_q    <= comp_n;
			elapsed_q <= elapsed_n;
			final_q   <= final_n;
			slow_q    <= slow_n;
			phase_q   <= phase_n;
			intv_q    <= intv_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_n;
	end

	assign out_valid    = res_valid_q;
	assign accepted     = res_q.accepted;
	assign base_pos     = res_q.pos[J_BASE];
	assign shoulder_pos = res_q.pos[J_SHOULDER];
	assign elbow_pos    = res_q.pos[J_ELBOW];
	assign grip_pos     = res_q.pos[J_GRIP];
	assign write_mask   = res_q.write_mask;
	assign compensating = res_q.compensating;
	assign slow_mode    = res_q.slow_mode;

	`ASSERT_IMPL(a_mask_only_on_tick, res_valid_q && (res_q.write_mask != 4'd0), !res_q.accepted, "servo write on a set command")
	`ASSERT_IMPL(a_comp_starts_on_set, $rose(comp_q), res_valid_q && res_q.accepted, "compensation started without an accepted set")
	`ASSERT_ALWAYS(a_phase_in_range, (phase_q == 8'd0) || (phase_q < intv_q), "step phase beyond interval")
	`ASSERT_IMPL(a_stall_needs_item, in_stall, valid_s1, "input stalled with empty item register")

endmodule

`default_nettype wire
